@@ hw/rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table package
// Shared types and codes for the task table, its memory entry and its checker.
// ----------------------------------------------------------------------------
package ptt_pkg;

   typedef enum logic [2:0] {
      ACT_TICK       = 3'd0,
      ACT_ADD        = 3'd1,
      ACT_REMOVE     = 3'd2,
      ACT_RESCHEDULE = 3'd3,
      ACT_ENABLE     = 3'd4,
      ACT_DISABLE    = 3'd5,
      ACT_RUN_NOW    = 3'd6,
      ACT_DISPATCH   = 3'd7
   } ptt_action_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_ADD_REJECT = 2'd1,
      STAT_NONE_READY = 2'd2,
      STAT_NOT_FOUND  = 2'd3
   } ptt_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_RUN  = 2'd1,
      FSM_FIN  = 2'd2
   } ptt_state_type;

   typedef struct packed {
      logic [15:0] handle;
      logic [15:0] period;
      logic [15:0] countdown;
      logic        ready;
      logic        enabled;
   } ptt_entry_type;

endpackage

@@ hw/rtl/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/periodic_task_timer_table.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table
// Slot table of a run-to-completion periodic task scheduler, held in one RAM.
// ----------------------------------------------------------------------------
// The table lives in a single RAM with one entry per slot; every command that
// needs a lookup reads it through the one read port and writes changed entries
// back. Tick, dispatch and the by-handle commands sweep the slots one per
// cycle (dispatch and by-handle commands end early at the first hit). Add,
// run-now and by-slot commands touch one entry. Rejections that need no table
// lookup go straight to the result. One item is worked on at a time; the result
// register frees the engine while a result waits to be taken. There is no
// clearing pass: per-slot valid bits make never-written slots read as empty.
module periodic_task_timer_table #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic        req_by_handle,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_handle,
   input  logic [15:0] req_period,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_chosen_slot,
   output logic [15:0] rsp_chosen_handle,
   output logic [15:0] rsp_tick_total
);

   localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int EW = $bits(ptt_pkg::ptt_entry_type);
   localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

   ptt_pkg::ptt_state_type  state_ff, state_in;
   ptt_pkg::ptt_action_type act_ff, act_in;
   logic                    sweep_ff, sweep_in;
   logic [15:0]             handle_ff, handle_in;
   logic [15:0]             period_ff, period_in;
   logic                    issue_on_ff, issue_on_in;
   logic [AW-1:0]           iss_ff, iss_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           pend_addr_ff, pend_addr_in;
   logic [NUM_SLOTS-1:0]    valid_ff, valid_in;
   logic [15:0]             tick_ff, tick_in;
   ptt_pkg::ptt_status_type res_status_ff, res_status_in;
   logic [2:0]              res_slot_ff, res_slot_in;
   logic [15:0]             res_handle_ff, res_handle_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [2:0]              rsp_slot_ff, rsp_slot_in;
   logic [15:0]             rsp_handle_ff, rsp_handle_in;
   logic [15:0]             rsp_tick_ff, rsp_tick_in;

   logic                    req_accept;
   logic                    slot_oor;
   logic                    imm_done;
   logic                    op_done;
   logic                    out_free;
   logic                    is_last;
   logic                    wr_en;
   logic                    rd_en;
   logic [EW-1:0]           rd_data;
   ptt_pkg::ptt_entry_type  entry;
   ptt_pkg::ptt_entry_type  wr_entry;
   ptt_pkg::ptt_entry_type  ticked;
   ptt_pkg::ptt_entry_type  modified;

   assign req_accept = req_valid && !req_stall;
   assign slot_oor   = 32'(req_slot) >= NUM_SLOTS;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_last    = pend_addr_ff == LAST;
   assign entry      = valid_ff[pend_addr_ff] ? ptt_pkg::ptt_entry_type'(rd_data) : '0;

   ptt_ram #(
      .WIDTH(EW),
      .DEPTH(NUM_SLOTS)
   ) u_ptt_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pend_addr_ff),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(iss_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      ticked = entry;
      if (entry.handle != 16'd0 && entry.enabled && entry.countdown != 16'd0) begin
         if (entry.countdown == 16'd1) begin
            ticked.ready     = 1'b1;
            ticked.countdown = entry.period;
         end else begin
            ticked.countdown = entry.countdown - 16'd1;
         end
      end
   end

   always_comb begin
      modified = entry;
      case (act_ff)
         ptt_pkg::ACT_ADD: begin
            modified.handle    = handle_ff;
            modified.period    = period_ff;
            modified.countdown = period_ff;
            modified.ready     = 1'b0;
            modified.enabled   = 1'b1;
         end
         ptt_pkg::ACT_REMOVE: begin
            modified = '0;
         end
         ptt_pkg::ACT_RESCHEDULE: begin
            modified.period    = period_ff;
            modified.countdown = period_ff;
         end
         ptt_pkg::ACT_ENABLE: begin
            modified.enabled = 1'b1;
         end
         ptt_pkg::ACT_DISABLE: begin
            modified.enabled = 1'b0;
         end
         ptt_pkg::ACT_RUN_NOW: begin
            modified.ready   = 1'b1;
            modified.enabled = 1'b1;
         end
         ptt_pkg::ACT_DISPATCH: begin
            modified.ready = 1'b0;
         end
         default: begin
            modified = ticked;
         end
      endcase
   end

   always_comb begin
      act_in        = act_ff;
      sweep_in      = sweep_ff;
      handle_in     = handle_ff;
      period_in     = period_ff;
      issue_on_in   = issue_on_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      tick_in       = tick_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_tick_in   = rsp_tick_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_entry      = modified;
      imm_done      = 1'b0;
      op_done       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ptt_pkg::FSM_IDLE: begin
            if (req_accept) begin
               act_in        = ptt_pkg::ptt_action_type'(req_action);
               handle_in     = req_handle;
               period_in     = req_period;
               res_status_in = ptt_pkg::STAT_OK;
               res_slot_in   = 3'd0;
               res_handle_in = 16'd0;
               sweep_in      = 1'b0;
               issue_on_in   = 1'b1;
               iss_in        = AW'(req_slot);
               case (ptt_pkg::ptt_action_type'(req_action))
                  ptt_pkg::ACT_TICK, ptt_pkg::ACT_DISPATCH: begin
                     sweep_in = 1'b1;
                     iss_in   = '0;
                     if (req_action == ptt_pkg::ACT_TICK) begin
                        tick_in = tick_ff + 16'd1;
                     end
                  end
                  ptt_pkg::ACT_ADD: begin
                     if (slot_oor || req_handle == 16'd0) begin
                        res_status_in = ptt_pkg::STAT_ADD_REJECT;
                        imm_done      = 1'b1;
                     end
                  end
                  ptt_pkg::ACT_RUN_NOW: begin
                     if (slot_oor) begin
                        res_status_in = ptt_pkg::STAT_NOT_FOUND;
                        imm_done      = 1'b1;
                     end
                  end
                  default: begin
                     if (req_by_handle) begin
                        sweep_in = 1'b1;
                        iss_in   = '0;
                        if (req_handle == 16'd0) begin
                           res_status_in = ptt_pkg::STAT_NOT_FOUND;
                           imm_done      = 1'b1;
                        end
                     end else if (slot_oor) begin
                        res_status_in = ptt_pkg::STAT_NOT_FOUND;
                        imm_done      = 1'b1;
                     end
                  end
               endcase
               if (imm_done) begin
                  issue_on_in = 1'b0;
               end
            end
         end
         ptt_pkg::FSM_RUN: begin
            if (issue_on_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = iss_ff;
               iss_in       = iss_ff + AW'(1);
               if (!sweep_ff || iss_ff == LAST) begin
                  issue_on_in = 1'b0;
               end
            end
            if (pend_ff) begin
               case (act_ff)
                  ptt_pkg::ACT_TICK: begin
                     wr_en   = 1'b1;
                     op_done = is_last;
                  end
                  ptt_pkg::ACT_DISPATCH: begin
                     if (entry.handle != 16'd0 && entry.enabled && entry.ready) begin
                        wr_en         = 1'b1;
                        res_slot_in   = 3'(pend_addr_ff);
                        res_handle_in = entry.handle;
                        op_done       = 1'b1;
                     end else if (is_last) begin
                        res_status_in = ptt_pkg::STAT_NONE_READY;
                        op_done       = 1'b1;
                     end
                  end
                  ptt_pkg::ACT_ADD: begin
                     if (entry.handle != 16'd0) begin
                        res_status_in = ptt_pkg::STAT_ADD_REJECT;
                     end else begin
                        wr_en       = 1'b1;
                        res_slot_in = 3'(pend_addr_ff);
                     end
                     op_done = 1'b1;
                  end
                  ptt_pkg::ACT_RUN_NOW: begin
                     wr_en       = 1'b1;
                     res_slot_in = 3'(pend_addr_ff);
                     op_done     = 1'b1;
                  end
                  default: begin
                     if (!sweep_ff || entry.handle == handle_ff) begin
                        wr_en       = 1'b1;
                        res_slot_in = 3'(pend_addr_ff);
                        op_done     = 1'b1;
                     end else if (is_last) begin
                        res_status_in = ptt_pkg::STAT_NOT_FOUND;
                        op_done       = 1'b1;
                     end
                  end
               endcase
               if (op_done) begin
                  issue_on_in = 1'b0;
                  pend_in     = 1'b0;
               end
            end
         end
         ptt_pkg::FSM_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_handle_in = res_handle_ff;
               rsp_tick_in   = tick_ff;
            end
         end
         default: begin
         end
      endcase

      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[pend_addr_ff] = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptt_pkg::FSM_IDLE: begin
            if (req_accept) begin
               state_in = imm_done ? ptt_pkg::FSM_FIN : ptt_pkg::FSM_RUN;
            end
         end
         ptt_pkg::FSM_RUN: begin
            if (op_done) begin
               state_in = ptt_pkg::FSM_FIN;
            end
         end
         ptt_pkg::FSM_FIN: begin
            if (out_free) begin
               state_in = ptt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = ptt_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall         = state_ff != ptt_pkg::FSM_IDLE;
      rsp_valid         = rsp_valid_ff;
      rsp_status        = rsp_status_ff;
      rsp_chosen_slot   = rsp_slot_ff;
      rsp_chosen_handle = rsp_handle_ff;
      rsp_tick_total    = rsp_tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptt_pkg::FSM_IDLE;
         issue_on_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         tick_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_on_ff  <= issue_on_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      sweep_ff      <= sweep_in;
      handle_ff     <= handle_in;
      period_ff     <= period_in;
      iss_ff        <= iss_in;
      pend_addr_ff  <= pend_addr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_tick_ff   <= rsp_tick_in;
   end

endmodule

@@ hw/rtl/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table checker
// Port-level assertions on the task table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ptt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_chosen_slot,
   input logic [15:0] rsp_chosen_handle,
   input logic [15:0] rsp_tick_total
);

   // The table works on one item at a time, so it is busy right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("table took a second item without a busy cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_chosen_slot) && $stable(rsp_chosen_handle)
         && $stable(rsp_tick_total))
      else $error("stalled result item changed");

   // A failed command reports neither a slot nor a handle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ptt_pkg::STAT_OK |->
         rsp_chosen_slot == 3'd0 && rsp_chosen_handle == 16'd0)
      else $error("failed command reported a slot or handle");

   // After reset the table is idle and holds no result.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("table not idle after reset");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);
